// ===== hdl/nhe_pkg.sv =====
// Package for the normalised Hermite evaluator: shared types, codes and constants.
// Holds the floating-point unit request/response structs and the sequencer states.
// No dependencies.
package nhe_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 20;

  localparam logic [63:0] ONE_BITS       = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN    = 64'hFFF8_0000_0000_0000;
  localparam logic [63:0] SIGMA_MIN_BITS = $realtobits(1.0e-16);
  localparam logic [62:0] INF_MAG        = 63'h7FF0_0000_0000_0000;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DEGREE = 2'd1;
  localparam logic [1:0] ST_SIGMA  = 2'd2;

  typedef enum logic [1:0] {
    FOP_MUL,
    FOP_DIV,
    FOP_SUB
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

  typedef enum logic [3:0] {
    FS_IDLE,
    FS_MUL,
    FS_PRENORM,
    FS_DIVIDE,
    FS_ALIGN,
    FS_ADDSUB,
    FS_NORM,
    FS_DENORM,
    FS_ROUND
  } fpu_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIVU,
    SQ_MULU,
    SQ_MULR,
    SQ_SUB,
    SQ_DIVR,
    SQ_FIN
  } seq_state_t;

endpackage

// ===== hdl/nhe_fpu.sv =====
// Multi-cycle IEEE double unit: multiply, divide and subtract, round to nearest even.
// One operation at a time; shared normalise, denormalise and round steps.
// Depends on nhe_pkg.
module nhe_fpu (
  input  logic              clk,
  input  logic              rst,
  input  nhe_pkg::fpu_req_t req,
  output nhe_pkg::fpu_rsp_t rsp
);
  import nhe_pkg::*;

  localparam int RW = 108;

  fpu_state_t        state, state_next;
  logic              sgn, eff_sub;
  logic signed [13:0] ex, ea, eb;
  logic [RW-1:0]     r, bsh;
  logic              st, sb;
  logic [11:0]       d;
  logic [52:0]       ma, mb;
  logic [53:0]       rem;
  logic [55:0]       q;
  logic [5:0]        cnt;
  logic [63:0]       result;
  logic              done;

  // unpacked operands
  logic              a_s, b_s, b_se;
  logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic signed [13:0] a_e, b_e;
  logic [52:0]       a_m, b_m;
  logic              special;
  logic [63:0]       spec_res;
  logic              a_big;

  // step helpers
  logic [5:0]        lsh, rsh, psa, psb, ash;
  logic signed [13:0] amt;
  logic [26:0]       pa, pb;
  logic [53:0]       pp;
  logic [6:0]        pp_sh;
  logic              ge;
  logic [53:0]       rem_sub, rem_nx;
  logic [55:0]       q_nx;
  logic [RW:0]       diff;
  logic [52:0]       sig;
  logic              grd, stk, inc;
  logic [53:0]       sum54;
  logic [52:0]       sigf;
  logic signed [13:0] expf;
  logic [63:0]       rnd_res;

  function automatic logic [5:0] left_amt(input logic [RW-1:0] v, input logic signed [13:0] e);
    logic [5:0] s;
    if (v[RW-1 -: 32] == '0 && e > 14'sd32) s = 6'd32;
    else if (v[RW-1 -: 16] == '0 && e > 14'sd16) s = 6'd16;
    else if (v[RW-1 -: 8] == '0 && e > 14'sd8) s = 6'd8;
    else if (v[RW-1 -: 4] == '0 && e > 14'sd4) s = 6'd4;
    else if (v[RW-1 -: 2] == '0 && e > 14'sd2) s = 6'd2;
    else s = 6'd1;
    return s;
  endfunction

  function automatic logic [5:0] right_amt(input logic [13:0] n);
    logic [5:0] s;
    if (n >= 14'd32) s = 6'd32;
    else if (n >= 14'd16) s = 6'd16;
    else if (n >= 14'd8) s = 6'd8;
    else if (n >= 14'd4) s = 6'd4;
    else if (n >= 14'd2) s = 6'd2;
    else s = 6'd1;
    return s;
  endfunction

  function automatic logic [5:0] pre_amt(input logic [52:0] m);
    logic [5:0] s;
    if (m[52]) s = 6'd0;
    else if (m[52 -: 32] == '0) s = 6'd32;
    else if (m[52 -: 16] == '0) s = 6'd16;
    else if (m[52 -: 8] == '0) s = 6'd8;
    else if (m[52 -: 4] == '0) s = 6'd4;
    else if (m[52 -: 2] == '0) s = 6'd2;
    else s = 6'd1;
    return s;
  endfunction

  function automatic logic [63:0] quiet(input logic [63:0] v);
    return v | 64'h0008_0000_0000_0000;
  endfunction

  // operand decode and special results
  always_comb begin
    a_s    = req.a[63];
    b_s    = req.b[63];
    a_nan  = (req.a[62:52] == 11'h7FF) && (req.a[51:0] != '0);
    b_nan  = (req.b[62:52] == 11'h7FF) && (req.b[51:0] != '0);
    a_inf  = (req.a[62:52] == 11'h7FF) && (req.a[51:0] == '0);
    b_inf  = (req.b[62:52] == 11'h7FF) && (req.b[51:0] == '0);
    a_zero = (req.a[62:0] == '0);
    b_zero = (req.b[62:0] == '0);
    a_e    = (req.a[62:52] == '0) ? 14'sd1 : $signed({3'b000, req.a[62:52]});
    b_e    = (req.b[62:52] == '0) ? 14'sd1 : $signed({3'b000, req.b[62:52]});
    a_m    = {req.a[62:52] != '0, req.a[51:0]};
    b_m    = {req.b[62:52] != '0, req.b[51:0]};
    b_se   = (req.op == FOP_SUB) ? ~b_s : b_s;
    a_big  = {a_e, a_m} >= {b_e, b_m};
    special  = 1'b1;
    spec_res = DEFAULT_NAN;
    if (a_nan) begin
      spec_res = quiet(req.a);
    end else if (b_nan) begin
      spec_res = quiet(req.b);
    end else begin
      case (req.op)
        FOP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) spec_res = DEFAULT_NAN;
          else if (a_inf || b_inf) spec_res = {a_s ^ b_s, INF_MAG};
          else if (a_zero || b_zero) spec_res = {a_s ^ b_s, 63'd0};
          else special = 1'b0;
        end
        FOP_DIV: begin
          if ((a_inf && b_inf) || (a_zero && b_zero)) spec_res = DEFAULT_NAN;
          else if (a_inf || b_zero) spec_res = {a_s ^ b_s, INF_MAG};
          else if (b_inf || a_zero) spec_res = {a_s ^ b_s, 63'd0};
          else special = 1'b0;
        end
        FOP_SUB: begin
          if (a_inf && b_inf && (a_s != b_se)) spec_res = DEFAULT_NAN;
          else if (a_inf) spec_res = req.a;
          else if (b_inf) spec_res = {b_se, INF_MAG};
          else if (a_zero && b_zero) spec_res = {a_s & b_se, 63'd0};
          else special = 1'b0;
        end
        default: special = 1'b1;
      endcase
    end
  end

  // shared step datapath
  always_comb begin
    lsh = left_amt(r, ex);
    amt = 14'sd1 - ex;
    rsh = right_amt(amt);
    ash = right_amt({2'b00, d});
    psa = pre_amt(ma);
    psb = pre_amt(mb);
    case (cnt[1:0])
      2'd0: begin
        pa = ma[26:0]; pb = mb[26:0]; pp_sh = 7'd2;
      end
      2'd1: begin
        pa = ma[26:0]; pb = {1'b0, mb[52:27]}; pp_sh = 7'd29;
      end
      2'd2: begin
        pa = {1'b0, ma[52:27]}; pb = mb[26:0]; pp_sh = 7'd29;
      end
      default: begin
        pa = {1'b0, ma[52:27]}; pb = {1'b0, mb[52:27]}; pp_sh = 7'd56;
      end
    endcase
    pp      = pa * pb;
    ge      = rem >= {1'b0, mb};
    rem_sub = ge ? (rem - {1'b0, mb}) : rem;
    rem_nx  = {rem_sub[52:0], 1'b0};
    q_nx    = {q[54:0], ge};
    diff    = {r, 1'b0} - {bsh, sb};
    sig     = r[RW-1 -: 53];
    grd     = r[RW-54];
    stk     = (|r[RW-55:0]) | st;
    inc     = grd & (stk | sig[0]);
    sum54   = {1'b0, sig} + {53'd0, inc};
    if (sum54[53]) begin
      sigf = sum54[53:1];
      expf = ex + 14'sd1;
    end else begin
      sigf = sum54[52:0];
      expf = ex;
    end
    if (expf >= 14'sd2047) rnd_res = {sgn, INF_MAG};
    else if (!sigf[52]) rnd_res = {sgn, 11'd0, sigf[51:0]};
    else rnd_res = {sgn, expf[10:0], sigf[51:0]};
  end

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (req.start && !special) begin
          case (req.op)
            FOP_MUL: state_next = FS_MUL;
            FOP_DIV: state_next = FS_PRENORM;
            default: state_next = FS_ALIGN;
          endcase
        end
      end
      FS_MUL:     if (cnt[1:0] == 2'd3) state_next = FS_NORM;
      FS_PRENORM: if (ma[52] && mb[52]) state_next = FS_DIVIDE;
      FS_DIVIDE:  if (cnt == 6'd55) state_next = FS_NORM;
      FS_ALIGN:   if (d == '0) state_next = FS_ADDSUB;
      FS_ADDSUB:  state_next = FS_NORM;
      FS_NORM:    if (r[RW-1] || ex <= 14'sd1) state_next = FS_DENORM;
      FS_DENORM:  if (ex >= 14'sd1) state_next = FS_ROUND;
      FS_ROUND:   state_next = FS_IDLE;
      default:    state_next = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        FS_IDLE: begin
          if (req.start) begin
            if (special) begin
              result <= spec_res;
              done   <= 1'b1;
            end
            st  <= 1'b0;
            sb  <= 1'b0;
            cnt <= '0;
            r   <= '0;
            ma  <= a_m;
            mb  <= b_m;
            ea  <= a_e;
            eb  <= b_e;
            sgn <= a_s ^ b_s;
            ex  <= a_e + b_e - 14'sd1022;
            if (req.op == FOP_SUB) begin
              eff_sub <= a_s ^ b_se;
              sgn     <= a_big ? a_s : b_se;
              r       <= {1'b0, (a_big ? a_m : b_m), 54'd0};
              bsh     <= {1'b0, (a_big ? b_m : a_m), 54'd0};
              ex      <= (a_big ? a_e : b_e) + 14'sd1;
              d       <= a_big ? 12'(a_e - b_e) : 12'(b_e - a_e);
            end
          end
        end
        FS_MUL: begin
          r   <= r + ({54'd0, pp} << pp_sh);
          cnt <= cnt + 6'd1;
        end
        FS_PRENORM: begin
          // bring subnormal significands up to a leading one
          ma <= ma << psa;
          mb <= mb << psb;
          ea <= ea - $signed({8'd0, psa});
          eb <= eb - $signed({8'd0, psb});
          if (ma[52] && mb[52]) begin
            rem <= {1'b0, ma};
            q   <= '0;
            cnt <= '0;
            ex  <= ea - eb + 14'sd1023;
          end
        end
        FS_DIVIDE: begin
          rem <= rem_nx;
          q   <= q_nx;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) begin
            r  <= {q_nx, 52'd0};
            st <= (rem_nx != '0);
          end
        end
        FS_ALIGN: begin
          if (d > 12'd108) begin
            sb  <= sb | (|bsh);
            bsh <= '0;
            d   <= '0;
          end else if (d != '0) begin
            sb  <= sb | (|(bsh & ~({RW{1'b1}} << ash)));
            bsh <= bsh >> ash;
            d   <= d - {6'd0, ash};
          end
        end
        FS_ADDSUB: begin
          if (!eff_sub) begin
            r  <= r + bsh;
            st <= sb;
          end else begin
            r  <= diff[RW:1];
            st <= diff[0];
            // exact cancellation gives plus zero
            if (diff == '0) sgn <= 1'b0;
          end
        end
        FS_NORM: begin
          if (!r[RW-1] && ex > 14'sd1) begin
            r  <= r << lsh;
            ex <= ex - $signed({8'd0, lsh});
          end
        end
        FS_DENORM: begin
          if (amt > 14'sd108) begin
            st <= st | (|r);
            r  <= '0;
            ex <= 14'sd1;
          end else if (ex < 14'sd1) begin
            st <= st | (|(r & ~({RW{1'b1}} << rsh)));
            r  <= r >> rsh;
            ex <= ex + $signed({8'd0, rsh});
          end
        end
        FS_ROUND: begin
          result <= rnd_res;
          done   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ===== hdl/normalized_hermite_eval_top.sv =====
// Top level of the normalised probabilists' Hermite evaluator.
// Sequences the three-term recurrence on the shared unit in nhe_fpu; uses nhe_pkg.
//
// Usage:
//   Input channel s_*: one item per request: degree and x (IEEE double bits).
//   Output channel m_*: one item per request, value in m_tdata, status in m_tuser.
//   cfg_we/cfg_wdata write sigma (IEEE double bits); write only while idle.
// Sequence:
//   Each item first divides x by sigma, then, for degree n >= 1, runs n-1 recurrence
//   steps of multiply, multiply, subtract and divide on the one floating-point unit,
//   the restoring divider taking one quotient bit per cycle. Error items skip the unit.
//   One item is in work at a time; s_tready is high only when the sequencer is idle.
// Reset:
//   rst is synchronous; sigma returns to 1.0, any item in work and the held result
//   are dropped.
// Stall:
//   A finished result holds in the output register until m_tready; the next item
//   may be accepted meanwhile, and its result waits until the register frees.
module normalized_hermite_eval_top #(
  parameter int unsigned MAX_DEGREE = nhe_pkg::MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // [4:0] degree, [68:5] x_value, [71:69] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [63:0] poly_value
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import nhe_pkg::*;

  localparam int KW = (MAX_DEGREE < 2) ? 1 : $clog2(MAX_DEGREE + 1);

  seq_state_t  state, state_next;
  logic [63:0] scale_sigma;
  logic [4:0]  deg;
  logic [63:0] x_val, u_val, prev, cur, t1, t2;
  logic [KW-1:0] k;
  logic [KW-1:0] k_plus;
  logic        issued;
  logic [63:0] res_val;
  logic [1:0]  res_st;
  logic        sigma_ok, deg_bad, out_free, step_last;
  fpu_req_t    req;
  fpu_rsp_t    rsp;
  logic [63:0] root_tab [MAX_DEGREE+1];

  // square root of k by forty Newton steps in double; k = 0 starts at one to stay finite
  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_root
    localparam real KR  = real'(g);
    localparam real Y0  = (g == 0) ? 1.0 : KR;
    localparam real Y1  = 0.5 * (Y0 + KR / Y0);
    localparam real Y2  = 0.5 * (Y1 + KR / Y1);
    localparam real Y3  = 0.5 * (Y2 + KR / Y2);
    localparam real Y4  = 0.5 * (Y3 + KR / Y3);
    localparam real Y5  = 0.5 * (Y4 + KR / Y4);
    localparam real Y6  = 0.5 * (Y5 + KR / Y5);
    localparam real Y7  = 0.5 * (Y6 + KR / Y6);
    localparam real Y8  = 0.5 * (Y7 + KR / Y7);
    localparam real Y9  = 0.5 * (Y8 + KR / Y8);
    localparam real Y10 = 0.5 * (Y9 + KR / Y9);
    localparam real Y11 = 0.5 * (Y10 + KR / Y10);
    localparam real Y12 = 0.5 * (Y11 + KR / Y11);
    localparam real Y13 = 0.5 * (Y12 + KR / Y12);
    localparam real Y14 = 0.5 * (Y13 + KR / Y13);
    localparam real Y15 = 0.5 * (Y14 + KR / Y14);
    localparam real Y16 = 0.5 * (Y15 + KR / Y15);
    localparam real Y17 = 0.5 * (Y16 + KR / Y16);
    localparam real Y18 = 0.5 * (Y17 + KR / Y17);
    localparam real Y19 = 0.5 * (Y18 + KR / Y18);
    localparam real Y20 = 0.5 * (Y19 + KR / Y19);
    localparam real Y21 = 0.5 * (Y20 + KR / Y20);
    localparam real Y22 = 0.5 * (Y21 + KR / Y21);
    localparam real Y23 = 0.5 * (Y22 + KR / Y22);
    localparam real Y24 = 0.5 * (Y23 + KR / Y23);
    localparam real Y25 = 0.5 * (Y24 + KR / Y24);
    localparam real Y26 = 0.5 * (Y25 + KR / Y25);
    localparam real Y27 = 0.5 * (Y26 + KR / Y26);
    localparam real Y28 = 0.5 * (Y27 + KR / Y27);
    localparam real Y29 = 0.5 * (Y28 + KR / Y28);
    localparam real Y30 = 0.5 * (Y29 + KR / Y29);
    localparam real Y31 = 0.5 * (Y30 + KR / Y30);
    localparam real Y32 = 0.5 * (Y31 + KR / Y31);
    localparam real Y33 = 0.5 * (Y32 + KR / Y32);
    localparam real Y34 = 0.5 * (Y33 + KR / Y33);
    localparam real Y35 = 0.5 * (Y34 + KR / Y34);
    localparam real Y36 = 0.5 * (Y35 + KR / Y35);
    localparam real Y37 = 0.5 * (Y36 + KR / Y36);
    localparam real Y38 = 0.5 * (Y37 + KR / Y37);
    localparam real Y39 = 0.5 * (Y38 + KR / Y38);
    localparam real Y40 = 0.5 * (Y39 + KR / Y39);
    assign root_tab[g] = (g == 0) ? 64'd0 : $realtobits(Y40);
  end

  nhe_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign sigma_ok  = (scale_sigma[62:0] > SIGMA_MIN_BITS[62:0]) &&
                     (scale_sigma[62:0] <= INF_MAG);
  assign deg_bad   = {1'b0, s_tdata[4:0]} > 6'(MAX_DEGREE);
  assign out_free  = !m_tvalid || m_tready;
  assign k_plus    = KW'(k + 1'b1);
  assign step_last = (6'(k) + 6'd1) == {1'b0, deg};

  always_comb begin
    state_next = state;
    case (state)
      SQ_IDLE: begin
        if (s_tvalid) begin
          state_next = (!sigma_ok || deg_bad) ? SQ_FIN : SQ_DIVU;
        end
      end
      SQ_DIVU: if (rsp.done) state_next = (deg < 5'd2) ? SQ_FIN : SQ_MULU;
      SQ_MULU: if (rsp.done) state_next = SQ_MULR;
      SQ_MULR: if (rsp.done) state_next = SQ_SUB;
      SQ_SUB:  if (rsp.done) state_next = SQ_DIVR;
      SQ_DIVR: if (rsp.done) state_next = step_last ? SQ_FIN : SQ_MULU;
      SQ_FIN:  if (out_free) state_next = SQ_IDLE;
      default: state_next = SQ_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == SQ_IDLE);
    req.start = 1'b0;
    req.op    = FOP_MUL;
    req.a     = u_val;
    req.b     = cur;
    case (state)
      SQ_DIVU: begin
        req.start = !issued;
        req.op    = FOP_DIV;
        req.a     = x_val;
        req.b     = scale_sigma;
      end
      SQ_MULU: begin
        req.start = !issued;
      end
      SQ_MULR: begin
        req.start = !issued;
        req.a     = root_tab[k];
        req.b     = prev;
      end
      SQ_SUB: begin
        req.start = !issued;
        req.op    = FOP_SUB;
        req.a     = t1;
        req.b     = t2;
      end
      SQ_DIVR: begin
        req.start = !issued;
        req.op    = FOP_DIV;
        req.a     = t1;
        req.b     = root_tab[k_plus];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SQ_IDLE;
      issued      <= 1'b0;
      m_tvalid    <= 1'b0;
      scale_sigma <= ONE_BITS;
    end else begin
      state <= state_next;
      if (cfg_we) scale_sigma <= cfg_wdata;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (req.start) issued <= 1'b1;
      if (rsp.done) issued <= 1'b0;
      case (state)
        SQ_IDLE: begin
          if (s_tvalid) begin
            deg     <= s_tdata[4:0];
            x_val   <= s_tdata[68:5];
            res_val <= '0;
            if (!sigma_ok) res_st <= ST_SIGMA;
            else if (deg_bad) res_st <= ST_DEGREE;
            else res_st <= ST_OK;
          end
        end
        SQ_DIVU: begin
          if (rsp.done) begin
            u_val   <= rsp.result;
            cur     <= rsp.result;
            prev    <= ONE_BITS;
            k       <= KW'(1);
            res_val <= (deg == 5'd0) ? ONE_BITS : rsp.result;
          end
        end
        SQ_MULU: if (rsp.done) t1 <= rsp.result;
        SQ_MULR: if (rsp.done) t2 <= rsp.result;
        SQ_SUB:  if (rsp.done) t1 <= rsp.result;
        SQ_DIVR: begin
          if (rsp.done) begin
            prev    <= cur;
            cur     <= rsp.result;
            k       <= k_plus;
            res_val <= rsp.result;
          end
        end
        SQ_FIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_val;
            m_tuser  <= res_st;
          end
        end
        default: ;
      endcase
    end
  end

  a_done_in_op: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == SQ_DIVU || state == SQ_MULU || state == SQ_MULR ||
                  state == SQ_SUB || state == SQ_DIVR))
    else $error("result from the arithmetic unit outside an operation step");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 64'd0))
    else $error("error item carries a non-zero value");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == SQ_MULU) |-> (6'(k) < {1'b0, deg}))
    else $error("recurrence index ran past the degree");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != SQ_IDLE))
    else $error("sequencer idle right after accepting an item");

endmodule
